// ----- src/stereo_biquad_fixed_point_filter_defines.svh -----
// assertion macros for the stereo biquad filter
`ifndef STEREO_BIQUAD_FIXED_POINT_FILTER_DEFINES_SVH
`define STEREO_BIQUAD_FIXED_POINT_FILTER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define BIQ_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define BIQ_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/biq_pkg.sv -----
`default_nettype none

package biq_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 32;
    localparam int COEF_W   = 34;
    localparam int COEF_LO_W = 17;
    localparam int ACC_W    = 63;
    localparam int FRAC_W   = 31;
    localparam int SHIFT_OUT = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W   = 4;
    localparam int PROD_W   = 3;
    localparam int CHANNELS_DEFAULT = 2;

    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] B0_RESET = 34'sd2131640587;
    localparam logic signed [COEF_W-1:0] B1_RESET = -34'sd4263281174;
    localparam logic signed [COEF_W-1:0] B2_RESET = 34'sd2131640587;
    localparam logic signed [COEF_W-1:0] A1_RESET = -34'sd4263164224;
    localparam logic signed [COEF_W-1:0] A2_RESET = 34'sd2115914356;

    // product order through the shared multiplier
    localparam logic [PROD_W-1:0] PROD_B0 = 3'd0;
    localparam logic [PROD_W-1:0] PROD_B1 = 3'd1;
    localparam logic [PROD_W-1:0] PROD_A1 = 3'd2;
    localparam logic [PROD_W-1:0] PROD_B2 = 3'd3;
    localparam logic [PROD_W-1:0] PROD_A2 = 3'd4;

    // steps at which a finished product is taken
    localparam logic [STEP_W-1:0] STEP_Y    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_T1   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_W1   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_T2   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef struct packed {
        logic               run;
        logic [STEP_W-1:0]  step;
        logic               mac_en;
        logic               mac_hi;
        logic               finish;
    } ctrl_t;

endpackage

`default_nettype wire

// ----- src/biq_mac.sv -----
`default_nettype none

module biq_mac import biq_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic                      hi,
    input  wire logic signed [DATA_W-1:0]  a,
    input  wire logic signed [COEF_W-1:0]  c,
    output logic        [DATA_W-1:0]       q
);

    logic signed [COEF_LO_W:0]          b;
    logic signed [DATA_W+COEF_LO_W:0]   prod;
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [ACC_W-1:0]            acc_next;

    // low part unsigned, high part signed: a*c = a*lo + (a*hi << 17)
    always_comb begin
        if (hi) begin
            b = {c[COEF_W-1], c[COEF_W-1:COEF_LO_W]};
        end else begin
            b = {1'b0, c[COEF_LO_W-1:0]};
        end
        prod = a * b;
        if (hi) begin
            acc_next = acc_reg + (ACC_W'(prod) <<< COEF_LO_W);
        end else begin
            acc_next = ACC_W'(prod);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_next;
        end
    end

    assign q = acc_reg[FRAC_W+DATA_W-1:FRAC_W];

endmodule

`default_nettype wire

// ----- src/biq_ctrl.sv -----
`default_nettype none

module biq_ctrl import biq_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  start,
    input  wire logic  out_free,
    output ctrl_t      ctrl
);

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               at_last;

    assign at_last = (step_reg == STEP_LAST);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (!at_last) begin
                    step_next = step_reg + 1'b1;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        ctrl.run    = (state_reg == ST_RUN);
        ctrl.step   = step_reg;
        ctrl.mac_en = ctrl.run && !at_last;
        ctrl.mac_hi = step_reg[0];
        ctrl.finish = ctrl.run && at_last && out_free;
    end

endmodule

`default_nettype wire

// ----- src/stereo_biquad_fixed_point_filter.sv -----
// Stereo biquad, transposed direct form II, with one pair of delay words per channel.
// A sample enters on s_ (tdata the sample, tuser the channel) and its filtered sample
// leaves on m_ with the same channel; s_tready is low while a sample is in work, so a
// new sample is not taken until the one before it is through. This comes from the
// single 32 x 18 bit multiplier, which forms each of the five coefficient products in
// two passes (low and high half of the coefficient). A result waiting on m_ does not
// block the next sample from entering; only the final step waits for it.
// Coefficients are 34-bit signed with 31 fraction bits, written through cfg_ (index 0 to
// 4: b0, b1, b2, a1, a2); writes to other indexes are dropped. Channels at or beyond
// CHANNELS share the delay state of channel 0.
`default_nettype none

module stereo_biquad_fixed_point_filter import biq_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SAMPLE_W-1:0]   s_tdata,   // sample_in
    input  wire logic                  s_tuser,   // channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [SAMPLE_W-1:0]   m_tdata,   // sample_out
    output logic                       m_tuser,   // channel_out
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COEF_W-1:0]     cfg_data
);

    localparam int KW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    ctrl_t                      ctrl;
    logic                       s_accept;
    logic                       out_free;
    logic signed [COEF_W-1:0]   coef_reg [5];
    logic signed [DATA_W-1:0]   x_reg;
    logic signed [DATA_W-1:0]   y_reg;
    logic        [DATA_W-1:0]   t_reg;
    logic                       chan_reg;
    logic        [KW-1:0]       k_reg;
    logic        [DATA_W-1:0]   w1_reg [CHANNELS];
    logic        [DATA_W-1:0]   w2_reg [CHANNELS];
    logic                       m_valid_reg;
    logic        [SAMPLE_W-1:0] m_data_reg;
    logic                       m_user_reg;
    logic        [PROD_W-1:0]   prod_idx;
    logic signed [DATA_W-1:0]   mac_a;
    logic signed [COEF_W-1:0]   mac_c;
    logic        [DATA_W-1:0]   mac_q;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = !ctrl.run;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    biq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // operand selection for the shared multiplier
    assign prod_idx = ctrl.step[STEP_W-1:1];

    always_comb begin
        mac_a = ((prod_idx == PROD_A1) || (prod_idx == PROD_A2)) ? y_reg : x_reg;
        case (prod_idx)
            PROD_B1: mac_c = coef_reg[REG_B1];
            PROD_A1: mac_c = coef_reg[REG_A1];
            PROD_B2: mac_c = coef_reg[REG_B2];
            PROD_A2: mac_c = coef_reg[REG_A2];
            default: mac_c = coef_reg[REG_B0];
        endcase
    end

    biq_mac u_mac (
        .aclk (aclk),
        .en   (ctrl.mac_en),
        .hi   (ctrl.mac_hi),
        .a    (mac_a),
        .c    (mac_c),
        .q    (mac_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[REG_B0] <= B0_RESET;
            coef_reg[REG_B1] <= B1_RESET;
            coef_reg[REG_B2] <= B2_RESET;
            coef_reg[REG_A1] <= A1_RESET;
            coef_reg[REG_A2] <= A2_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_B0:  coef_reg[REG_B0] <= cfg_data;
                REG_B1:  coef_reg[REG_B1] <= cfg_data;
                REG_B2:  coef_reg[REG_B2] <= cfg_data;
                REG_A1:  coef_reg[REG_A1] <= cfg_data;
                REG_A2:  coef_reg[REG_A2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg    <= {s_tdata, {SHIFT_OUT{1'b0}}};
            chan_reg <= s_tuser;
            k_reg    <= (32'(s_tuser) < CHANNELS) ? KW'(s_tuser) : '0;
        end
        if (ctrl.run && (ctrl.step == STEP_Y)) begin
            y_reg <= w1_reg[k_reg] + mac_q;
        end
        if (ctrl.run && (ctrl.step == STEP_T1)) begin
            t_reg <= w2_reg[k_reg] + mac_q;
        end
        if (ctrl.run && (ctrl.step == STEP_T2)) begin
            t_reg <= mac_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                w1_reg[i] <= '0;
                w2_reg[i] <= '0;
            end
        end else begin
            if (ctrl.run && (ctrl.step == STEP_W1)) begin
                w1_reg[k_reg] <= t_reg - mac_q;
            end
            if (ctrl.finish) begin
                w2_reg[k_reg] <= t_reg - mac_q;
            end
        end
    end

    // output register, one transaction deep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.finish) begin
            m_data_reg <= y_reg[DATA_W-1:SHIFT_OUT];
            m_user_reg <= chan_reg;
        end
    end

endmodule

`default_nettype wire

// ----- src/biq_checker.sv -----
`default_nettype none
`include "stereo_biquad_fixed_point_filter_defines.svh"

module biq_checker import biq_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [SAMPLE_W-1:0]   m_tdata,
    input wire logic                  m_tuser
);

    `BIQ_ASSERT_NEXT(a_out_valid_held, m_tvalid && !m_tready, m_tvalid,
        "result dropped while stalled")

    `BIQ_ASSERT_NEXT(a_out_data_held, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `BIQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input taken again while busy")

    `BIQ_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready),
        "result without a sample in work")

endmodule

bind stereo_biquad_fixed_point_filter biq_checker u_biq_checker (.*);

`default_nettype wire
